// ===== src/wav_pkg.sv =====
// shared constants, codes and types for the windowed axis velocity block
// no dependencies; imported by every module of the block
package wav_pkg;

  localparam int RING_DEPTH_DEF = 64;

  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SAMPLES = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE     = 8'd1;

  localparam logic [6:0]  MIN_SAMPLES_RST = 7'd2;
  localparam logic [15:0] MAX_AGE_RST     = 16'd100;

  localparam logic [1:0] FUNC_POS   = 2'd0;
  localparam logic [1:0] FUNC_QUERY = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_FEW  = 2'd1;
  localparam logic [1:0] STAT_ZERO = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_FIRST,
    ST_PREV,
    ST_WALK,
    ST_DIVGO,
    ST_DIVWAIT,
    ST_OUT
  } state_t;

endpackage

// ===== src/wav_ring.sv =====
// sample ring storage: movement and timestamp per entry
// one write port, one read port with registered read data; uses wav_pkg
module wav_ring import wav_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          we,
  input  logic [$clog2(RING_DEPTH)-1:0] waddr,
  input  logic [31:0]                   wmov,
  input  logic [31:0]                   wtime,
  input  logic [$clog2(RING_DEPTH)-1:0] raddr,
  output logic [31:0]                   rmov,
  output logic [31:0]                   rtime
);

  logic [63:0] mem [RING_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wtime, wmov};
    end
  end

  always_ff @(posedge clk) begin
    {rtime, rmov} <= mem[raddr];
  end

endmodule

// ===== src/wav_div.sv =====
// restoring unsigned divider, one quotient bit per cycle
// start loads operands, done pulses when the quotient is ready; uses wav_pkg
module wav_div import wav_pkg::*; #(
  parameter int NUM_W = 46,
  parameter int DEN_W = 38
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] dividend,
  input  logic [DEN_W-1:0] divisor,
  output logic             done,
  output logic [NUM_W-1:0] quotient
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy;
  logic [CW-1:0]    cnt;
  logic [DEN_W:0]   rem;
  logic [NUM_W-1:0] quo;
  logic [DEN_W-1:0] den;
  logic [DEN_W:0]   shifted;
  logic [DEN_W:0]   diff;
  logic             ge;

  always_comb begin
    shifted = {rem[DEN_W-1:0], quo[NUM_W-1]};
    ge      = shifted >= {1'b0, den};
    diff    = shifted - {1'b0, den};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= '0;
        quo  <= dividend;
        den  <= divisor;
        cnt  <= CW'(NUM_W);
      end else if (busy) begin
        rem <= ge ? diff : shifted;
        quo <= {quo[NUM_W-2:0], ge};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

// ===== src/wav_seq.sv =====
// sequencer and datapath: position update, ring walk, divider control,
// output register; drives wav_ring and wav_div, uses wav_pkg
module wav_seq import wav_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_func,
  input  logic [31:0]                         in_position,
  input  logic [31:0]                         in_timestamp,
  input  logic [6:0]                          min_samples,
  input  logic [15:0]                         max_age_ms,
  output logic                                ring_we,
  output logic [$clog2(RING_DEPTH)-1:0]       ring_waddr,
  output logic [31:0]                         ring_wmov,
  output logic [31:0]                         ring_wtime,
  output logic [$clog2(RING_DEPTH)-1:0]       ring_raddr,
  input  logic [31:0]                         ring_rmov,
  input  logic [31:0]                         ring_rtime,
  output logic                                div_start,
  output logic [32+$clog2(RING_DEPTH)+7:0]    div_dividend,
  output logic [32+$clog2(RING_DEPTH)-1:0]    div_divisor,
  input  logic                                div_done,
  input  logic [32+$clog2(RING_DEPTH)+7:0]    div_quotient,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [31:0]                         out_velocity,
  output logic [1:0]                          out_status,
  output logic                                out_changed,
  output logic [31:0]                         out_tracked
);

  localparam int IDX_W  = $clog2(RING_DEPTH);
  localparam int CNT_W  = $clog2(RING_DEPTH + 1);
  localparam int CMP_W  = (CNT_W > 7) ? CNT_W : 7;
  localparam int DIST_W = 32 + IDX_W;
  localparam int NUM_W  = DIST_W + 8;
  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(RING_DEPTH);

  state_t state, state_next;

  logic [1:0]         func_r;
  logic [31:0]        pos_r;
  logic [31:0]        now_r;
  logic [IDX_W-1:0]   wi;
  logic [CNT_W-1:0]   cnt;
  logic [31:0]        tracked;
  logic [IDX_W-1:0]   rd_idx;
  logic [CNT_W-1:0]   step;
  logic [31:0]        prev_t;
  logic [DIST_W-1:0]  dist_acc;
  logic [DIST_W-1:0]  total;
  logic [31:0]        vel;
  logic [1:0]         status;
  logic               changed;

  logic               few;
  logic [IDX_W-1:0]   wi_inc;
  logic [CNT_W-1:0]   cnt_inc;
  logic [CNT_W:0]     wi_ext;
  logic [CNT_W:0]     c_ext;
  logic [CNT_W:0]     oldest_full;
  logic [IDX_W-1:0]   rd_inc;
  logic [32:0]        diff;
  logic [31:0]        mov_sat;
  logic [31:0]        age;
  logic               in_win;
  logic [31:0]        gap;
  logic [DIST_W-1:0]  dist_sum;
  logic [DIST_W-1:0]  total_sum;
  logic [DIST_W-1:0]  abs_dist;
  logic [31:0]        vel_sat;
  logic               out_free;

  always_comb begin
    few     = CMP_W'(cnt) < CMP_W'(min_samples);
    wi_inc  = (wi == LAST_IDX) ? '0 : wi + IDX_W'(1);
    cnt_inc = (cnt == DEPTH_CNT) ? cnt : cnt + CNT_W'(1);
    // oldest entry after the idle sample has gone in
    wi_ext  = (CNT_W+1)'(wi_inc);
    c_ext   = (CNT_W+1)'(cnt_inc);
    oldest_full = (c_ext > wi_ext) ? wi_ext + (CNT_W+1)'(RING_DEPTH) - c_ext
                                   : wi_ext - c_ext;
    rd_inc  = (rd_idx == LAST_IDX) ? '0 : rd_idx + IDX_W'(1);

    diff = {pos_r[31], pos_r} - {tracked[31], tracked};
    if (diff[32] != diff[31]) begin
      mov_sat = diff[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      mov_sat = diff[31:0];
    end

    age       = now_r - ring_rtime;
    in_win    = age <= {16'b0, max_age_ms};
    gap       = ring_rtime - prev_t;
    dist_sum  = dist_acc + {{IDX_W{ring_rmov[31]}}, ring_rmov};
    total_sum = total + {{IDX_W{1'b0}}, gap};

    abs_dist = dist_acc[DIST_W-1] ? (~dist_acc + DIST_W'(1)) : dist_acc;
    if (!dist_acc[DIST_W-1]) begin
      vel_sat = (div_quotient[NUM_W-1:31] != '0) ? 32'h7fff_ffff : div_quotient[31:0];
    end else if ((div_quotient[NUM_W-1:32] != '0) ||
                 (div_quotient[31] && (div_quotient[30:0] != '0))) begin
      vel_sat = 32'h8000_0000;
    end else begin
      vel_sat = ~div_quotient[31:0] + 32'd1;
    end

    out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    ring_we    = 1'b0;
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        if (func_r == FUNC_POS) begin
          ring_we    = 1'b1;
          state_next = ST_OUT;
        end else if (func_r == FUNC_QUERY && !few) begin
          ring_we    = 1'b1;
          state_next = ST_FIRST;
        end else begin
          state_next = ST_OUT;
        end
      end
      ST_FIRST: state_next = ST_PREV;
      ST_PREV: begin
        state_next = (cnt <= CNT_W'(1)) ? ST_DIVGO : ST_WALK;
      end
      ST_WALK: begin
        if (step == cnt - CNT_W'(1)) begin
          state_next = ST_DIVGO;
        end
      end
      ST_DIVGO: begin
        if (total == '0) begin
          state_next = ST_OUT;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIVWAIT;
        end
      end
      ST_DIVWAIT: begin
        if (div_done) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  assign ring_waddr   = wi;
  assign ring_wmov    = (func_r == FUNC_POS) ? mov_sat : 32'd0;
  assign ring_wtime   = now_r;
  assign ring_raddr   = rd_idx;
  assign div_dividend = {abs_dist, 8'b0};
  assign div_divisor  = total;

  always_ff @(posedge clk) begin
    if (rst) begin
      wi        <= '0;
      cnt       <= '0;
      tracked   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            func_r  <= in_func;
            pos_r   <= in_position;
            now_r   <= in_timestamp;
            vel     <= '0;
            status  <= STAT_OK;
            changed <= 1'b0;
          end
        end
        ST_DECODE: begin
          case (func_r)
            FUNC_POS: begin
              wi  <= wi_inc;
              cnt <= cnt_inc;
              if (pos_r != tracked) begin
                tracked <= pos_r;
                changed <= 1'b1;
              end
            end
            FUNC_QUERY: begin
              if (few) begin
                status <= STAT_FEW;
              end else begin
                wi       <= wi_inc;
                cnt      <= cnt_inc;
                rd_idx   <= oldest_full[IDX_W-1:0];
                dist_acc <= '0;
                total    <= '0;
              end
            end
            FUNC_CLEAR: begin
              wi  <= '0;
              cnt <= '0;
            end
            default: ;
          endcase
        end
        ST_FIRST: rd_idx <= rd_inc;
        ST_PREV: begin
          prev_t <= ring_rtime;
          rd_idx <= rd_inc;
          step   <= CNT_W'(1);
        end
        ST_WALK: begin
          // newest time is the query time itself
          if (in_win) begin
            dist_acc <= dist_sum;
            total    <= total_sum;
          end
          prev_t <= ring_rtime;
          rd_idx <= rd_inc;
          step   <= step + CNT_W'(1);
        end
        ST_DIVGO: begin
          if (total == '0) begin
            status <= STAT_ZERO;
          end
        end
        ST_DIVWAIT: begin
          if (div_done) begin
            vel <= vel_sat;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid    <= 1'b1;
            out_velocity <= vel;
            out_status   <= status;
            out_changed  <= changed;
            out_tracked  <= tracked;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== src/windowed_axis_velocity.sv =====
// channel    | signals                                  | contents
// s_axis     | s_axis_tvalid/tready/tdata/tuser         | position and timestamp, func
// m_axis     | m_axis_tvalid/tready/tdata               | velocity, status, change, position
// cfg        | cfg_valid/cfg_ready/cfg_index/cfg_data   | register writes, always ready
//
// position and clear transactions pass decode, then the output step, to the result
// a query does one ring read per stored sample
// through the single read port, then one quotient bit per cycle in the divider
// reset clears count, write index and tracked position; ring contents are left as is
// a result not yet taken holds the block in its last step; input is taken only when idle
module windowed_axis_velocity import wav_pkg::*; #(
  parameter int RING_DEPTH = RING_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [63:0]           s_axis_tdata,   // position[31:0], timestamp_ms[63:32]
  input  logic [1:0]            s_axis_tuser,   // func[1:0]
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [71:0]           m_axis_tdata,   // velocity[31:0], status[33:32],
                                                // position_changed[34],
                                                // tracked_position[66:35], zero[71:67]
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W  = $clog2(RING_DEPTH);
  localparam int DIST_W = 32 + IDX_W;
  localparam int NUM_W  = DIST_W + 8;

  logic [6:0]        min_samples;
  logic [15:0]       max_age_ms;

  logic              ring_we;
  logic [IDX_W-1:0]  ring_waddr;
  logic [31:0]       ring_wmov;
  logic [31:0]       ring_wtime;
  logic [IDX_W-1:0]  ring_raddr;
  logic [31:0]       ring_rmov;
  logic [31:0]       ring_rtime;
  logic              div_start;
  logic [NUM_W-1:0]  div_dividend;
  logic [DIST_W-1:0] div_divisor;
  logic              div_done;
  logic [NUM_W-1:0]  div_quotient;
  logic [31:0]       out_velocity;
  logic [1:0]        out_status;
  logic              out_changed;
  logic [31:0]       out_tracked;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_samples <= MIN_SAMPLES_RST;
      max_age_ms  <= MAX_AGE_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MIN_SAMPLES: min_samples <= cfg_data[6:0];
        CFG_MAX_AGE:     max_age_ms  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  wav_seq #(.RING_DEPTH(RING_DEPTH)) u_seq (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .in_func      (s_axis_tuser),
    .in_position  (s_axis_tdata[31:0]),
    .in_timestamp (s_axis_tdata[63:32]),
    .min_samples  (min_samples),
    .max_age_ms   (max_age_ms),
    .ring_we      (ring_we),
    .ring_waddr   (ring_waddr),
    .ring_wmov    (ring_wmov),
    .ring_wtime   (ring_wtime),
    .ring_raddr   (ring_raddr),
    .ring_rmov    (ring_rmov),
    .ring_rtime   (ring_rtime),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_divisor  (div_divisor),
    .div_done     (div_done),
    .div_quotient (div_quotient),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_velocity (out_velocity),
    .out_status   (out_status),
    .out_changed  (out_changed),
    .out_tracked  (out_tracked)
  );

  wav_ring #(.RING_DEPTH(RING_DEPTH)) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (ring_waddr),
    .wmov  (ring_wmov),
    .wtime (ring_wtime),
    .raddr (ring_raddr),
    .rmov  (ring_rmov),
    .rtime (ring_rtime)
  );

  wav_div #(.NUM_W(NUM_W), .DEN_W(DIST_W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign m_axis_tdata = {5'b0, out_tracked, out_changed, out_status, out_velocity};

endmodule

// ===== src/wav_chk.sv =====
// port-level checks for windowed_axis_velocity, attached by bind
// depends on wav_pkg for status codes
module wav_chk import wav_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata
);

  // output register is empty straight after reset
  a_rst_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result present after reset");

  // the block works on one transaction at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken again while busy");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // a failed query carries no velocity and no position change
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[33:32] != STAT_OK) |->
      (m_axis_tdata[31:0] == 32'd0) && !m_axis_tdata[34])
    else $error("velocity or change flag set on failed query");

endmodule

bind windowed_axis_velocity wav_chk u_wav_chk (.*);

// ===== tb/tb.sv =====
// self-checking testbench for windowed_axis_velocity: a directed table, then random traffic
// with random stalls on both stream sides; each result is checked against its typed table entry or a local predictor
// depends on wav_pkg and windowed_axis_velocity
module tb import wav_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH = RING_DEPTH_DEF;
  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 8'd255;
  localparam int HOLD_AT     = 200;
  localparam int HOLD_CYCLES = 600;

  typedef struct packed {
    logic signed [31:0] vel;
    logic [1:0]         status;
    logic               changed;
    logic signed [31:0] pos;
  } vel_result_t;

  typedef struct {
    logic [1:0]  func;
    logic [31:0] pos;
    logic [31:0] ts;
    bit          typed;
    vel_result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_valid = 1'b0;
  logic [63:0] s_data = '0;
  logic [1:0] s_user = '0;
  logic m_ready = 1'b0;
  logic cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic s_axis_tready, m_axis_tvalid, cfg_ready;
  logic [71:0] m_axis_tdata;

  // predictor state
  logic signed [31:0] ring_move [DEPTH];
  logic [31:0]        ring_stamp [DEPTH];
  int                 ring_wr = 0;
  int                 ring_fill = 0;
  logic signed [31:0] cur_pos = '0;
  int                 min_fill_cfg = MIN_SAMPLES_RST;
  logic [15:0]        window_ms_cfg = MAX_AGE_RST;

  vel_result_t expected_results [$];
  stim_row_t   directed_rows [$];
  int          errors = 0;

  windowed_axis_velocity uut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_valid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_data),
    .s_axis_tuser (s_user),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_ready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin : clock_gen
    forever #1 clk = ~clk;
  end

  initial begin : watchdog
    #2_000_000;
    $display("tb: done, errors");
    $finish;
  end

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic void store_sample(logic signed [31:0] mov, logic [31:0] ts);
    ring_move[ring_wr] = mov;
    ring_stamp[ring_wr] = ts;
    ring_wr = (ring_wr + 1) % DEPTH;
    if (ring_fill < DEPTH) ring_fill++;
  endfunction

  function automatic vel_result_t estimate_velocity(logic [1:0] f, logic signed [31:0] p,
                                                    logic [31:0] ts);
    vel_result_t r;
    longint dist_acc, total;
    int oldest, idx;
    logic [31:0] newest_t, prev_t, t, age, gap;
    r = '0;
    case (f)
      FUNC_POS: begin
        store_sample(sat32(longint'(p) - longint'(cur_pos)), ts);
        if (p != cur_pos) begin
          cur_pos = p;
          r.changed = 1'b1;
        end
      end
      FUNC_QUERY: begin
        if (ring_fill < min_fill_cfg) begin
          r.status = STAT_FEW;
        end else begin
          // idle sample at query time closes the window
          store_sample('0, ts);
          oldest = (ring_wr + DEPTH - ring_fill) % DEPTH;
          newest_t = ring_stamp[(ring_wr + DEPTH - 1) % DEPTH];
          prev_t = ring_stamp[oldest];
          dist_acc = 0;
          total = 0;
          for (int i = 1; i < ring_fill; i++) begin
            idx = (oldest + i) % DEPTH;
            t = ring_stamp[idx];
            age = newest_t - t;
            if (age <= {16'd0, window_ms_cfg}) begin
              gap = t - prev_t;
              dist_acc = dist_acc + longint'(ring_move[idx]);
              total = total + longint'({32'd0, gap});
            end
            prev_t = t;
          end
          if (total == 0) r.status = STAT_ZERO;
          else r.vel = sat32((dist_acc * 256) / total);
        end
      end
      FUNC_CLEAR: begin
        ring_fill = 0;
        ring_wr = 0;
      end
      default: ;
    endcase
    r.pos = cur_pos;
    return r;
  endfunction

  task automatic row_pred(logic [1:0] f, logic [31:0] p, logic [31:0] ts);
    stim_row_t s;
    s.func = f; s.pos = p; s.ts = ts; s.typed = 1'b0; s.want = '0;
    directed_rows.push_back(s);
  endtask

  task automatic row_typed(logic [1:0] f, logic [31:0] p, logic [31:0] ts,
                           logic [31:0] vel, logic [1:0] st, logic chg, logic [31:0] trk);
    stim_row_t s;
    s.func = f; s.pos = p; s.ts = ts; s.typed = 1'b1;
    s.want.vel = vel; s.want.status = st; s.want.changed = chg; s.want.pos = trk;
    directed_rows.push_back(s);
  endtask

  // bursts of back-to-back transactions now and then, else a random gap
  task automatic draw_gap(inout int calm, output int gap);
    if (calm > 0) begin
      calm--;
      gap = 0;
    end else if ($urandom_range(0, 24) == 0) begin
      calm = $urandom_range(10, 50);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 16);
    end
  endtask

  int send_calm = 0;

  task automatic send_item(logic [1:0] f, logic [31:0] p, logic [31:0] ts,
                           bit typed, vel_result_t want);
    vel_result_t pred;
    int gap;
    s_valid <= 1'b1;
    s_data <= {ts, p};
    s_user <= f;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    pred = estimate_velocity(f, p, ts);
    expected_results.push_back(typed ? want : pred);
    draw_gap(send_calm, gap);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == CFG_MIN_SAMPLES) min_fill_cfg = val[6:0];
    else if (idx == CFG_MAX_AGE) window_ms_cfg = val;
  endtask

  task automatic wait_drained;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  initial begin : stimulus
    vel_result_t none;
    logic [1:0] f;
    logic signed [31:0] pos_now;
    logic [31:0] p, ts_now;
    int r, n_items;
    none = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    row_typed(FUNC_QUERY, 32'h0, 32'd0, 32'h0, STAT_FEW, 1'b0, 32'h0);
    row_typed(FUNC_NONE, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h0, STAT_OK, 1'b0, 32'h0);
    row_typed(FUNC_CLEAR, 32'hFFFFFFFF, 32'd0, 32'h0, STAT_OK, 1'b0, 32'h0);
    row_typed(FUNC_POS, 32'h0, 32'd0, 32'h0, STAT_OK, 1'b0, 32'h0);
    row_typed(FUNC_QUERY, 32'h0, 32'd10, 32'h0, STAT_FEW, 1'b0, 32'h0);
    row_typed(FUNC_POS, 32'h7FFFFFFF, 32'd10, 32'h0, STAT_OK, 1'b1, 32'h7FFFFFFF);
    // movement saturates negative
    row_typed(FUNC_POS, 32'h80000000, 32'd20, 32'h0, STAT_OK, 1'b1, 32'h80000000);
    row_pred(FUNC_QUERY, 32'h0, 32'd20);
    // movement saturates positive
    row_typed(FUNC_POS, 32'h7FFFFFFF, 32'd30, 32'h0, STAT_OK, 1'b1, 32'h7FFFFFFF);
    row_pred(FUNC_QUERY, 32'h0, 32'd30);
    row_typed(FUNC_CLEAR, 32'h0, 32'd40, 32'h0, STAT_OK, 1'b0, 32'h7FFFFFFF);
    row_typed(FUNC_POS, 32'h7FFFFFFF, 32'd100, 32'h0, STAT_OK, 1'b0, 32'h7FFFFFFF);
    row_typed(FUNC_POS, 32'h7FFFFFFF, 32'd100, 32'h0, STAT_OK, 1'b0, 32'h7FFFFFFF);
    // no time elapsed in the window
    row_typed(FUNC_QUERY, 32'h0, 32'd100, 32'h0, STAT_ZERO, 1'b0, 32'h7FFFFFFF);
    row_typed(FUNC_QUERY, 32'h0, 32'd100, 32'h0, STAT_ZERO, 1'b0, 32'h7FFFFFFF);
    // timestamp wrap, and a sample stamped after the query time
    row_pred(FUNC_POS, 32'h7FFFFC00, 32'hFFFFFFFF);
    row_pred(FUNC_POS, 32'h7FFFFFFF, 32'h00000010);
    row_pred(FUNC_POS, 32'h00001234, 32'h00001000);
    row_pred(FUNC_QUERY, 32'h0, 32'h00000020);
    // velocity saturates high, then low
    row_typed(FUNC_CLEAR, 32'h0, 32'd0, 32'h0, STAT_OK, 1'b0, 32'h00001234);
    row_typed(FUNC_POS, 32'h80000000, 32'd500, 32'h0, STAT_OK, 1'b1, 32'h80000000);
    row_typed(FUNC_POS, 32'h7FFFFFFF, 32'd501, 32'h0, STAT_OK, 1'b1, 32'h7FFFFFFF);
    row_typed(FUNC_QUERY, 32'h0, 32'd501, 32'h7FFFFFFF, STAT_OK, 1'b0, 32'h7FFFFFFF);
    row_typed(FUNC_CLEAR, 32'h0, 32'd0, 32'h0, STAT_OK, 1'b0, 32'h7FFFFFFF);
    row_typed(FUNC_POS, 32'h7FFFFFFF, 32'd600, 32'h0, STAT_OK, 1'b0, 32'h7FFFFFFF);
    row_typed(FUNC_POS, 32'h80000000, 32'd601, 32'h0, STAT_OK, 1'b1, 32'h80000000);
    row_typed(FUNC_QUERY, 32'h0, 32'd601, 32'h80000000, STAT_OK, 1'b0, 32'h80000000);

    foreach (directed_rows[i])
      send_item(directed_rows[i].func, directed_rows[i].pos, directed_rows[i].ts,
                directed_rows[i].typed, directed_rows[i].want);
    s_valid <= 1'b0;

    pos_now = cur_pos;
    for (int ph = 0; ph < 7; ph++) begin
      wait_drained();
      n_items = 290;
      case (ph)
        0: begin
          write_reg(CFG_MIN_SAMPLES, 16'd1);
          write_reg(CFG_MAX_AGE, 16'd0);
        end
        1: begin
          write_reg(CFG_MIN_SAMPLES, 16'd64);
          write_reg(CFG_MAX_AGE, 16'hFFFF);
        end
        2: begin
          write_reg(CFG_MIN_SAMPLES, 16'd3);
          write_reg(CFG_MAX_AGE, 16'd20);
        end
        3: begin
          // upper data bits are dropped: min_samples becomes 0
          write_reg(CFG_MIN_SAMPLES, 16'hFF80);
          write_reg(CFG_MAX_AGE, 16'd1000);
        end
        4: begin
          write_reg(CFG_MIN_SAMPLES, 16'h007F);
          n_items = 100;
        end
        5: begin
          write_reg(CFG_MIN_SAMPLES, 16'd16);
          write_reg(CFG_MAX_AGE, 16'd200);
          // writes to indexes with no register behind them
          write_reg(CFG_SPARE_LO, 16'h1234);
          write_reg(CFG_SPARE_HI, 16'hFFFF);
        end
        default: begin
          write_reg(CFG_MIN_SAMPLES, 16'hFF82);
          write_reg(CFG_MAX_AGE, 16'd100);
        end
      endcase
      cfg_valid <= 1'b0;
      ts_now = $urandom;
      for (int k = 0; k < n_items; k++) begin
        r = $urandom_range(0, 99);
        if (r < 3) f = FUNC_CLEAR;
        else if (r < 5) f = FUNC_NONE;
        else if (r < 25) f = FUNC_QUERY;
        else f = FUNC_POS;
        r = $urandom_range(0, 99);
        if (r < 4) ts_now = $urandom;
        else if (r < 8) ts_now = ts_now - $urandom_range(1, 200);
        else ts_now = ts_now + $urandom_range(0, 30);
        if (f == FUNC_POS) begin
          r = $urandom_range(0, 99);
          if (r < 5) pos_now = $urandom;
          else if (r < 10) pos_now = r[0] ? 32'sh7FFFFFFF : 32'sh80000000;
          else if (r < 30) pos_now = cur_pos;
          else if (r < 40) pos_now = cur_pos + $urandom_range(0, 2097152) - 1048576;
          else pos_now = cur_pos + $urandom_range(0, 4000) - 2000;
          p = pos_now;
        end else begin
          p = $urandom;
        end
        send_item(f, p, ts_now, 1'b0, none);
      end
      s_valid <= 1'b0;
    end

    wait_drained();
    repeat (130) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

  initial begin : result_check
    vel_result_t want, got;
    int stall, taken, calm;
    taken = 0;
    calm = 0;
    do @(posedge clk); while (rst);
    forever begin
      // one long hold-off so the block backs up onto its input
      if (taken == HOLD_AT) stall = HOLD_CYCLES;
      else draw_gap(calm, stall);
      if (stall > 0) begin
        m_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_ready <= 1'b1;
      do @(posedge clk); while (m_axis_tvalid !== 1'b1);
      taken++;
      got.vel = m_axis_tdata[31:0];
      got.status = m_axis_tdata[33:32];
      got.changed = m_axis_tdata[34];
      got.pos = m_axis_tdata[66:35];
      if (expected_results.size() == 0) begin
        $display("%0t: result transaction with nothing expected: %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = expected_results.pop_front();
        if (got.vel !== want.vel) begin
          $display("%0t: velocity expected %h got %h", $time, want.vel, got.vel);
          errors++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
          errors++;
        end
        if (got.changed !== want.changed) begin
          $display("%0t: position_changed expected %b got %b", $time, want.changed,
                   got.changed);
          errors++;
        end
        if (got.pos !== want.pos) begin
          $display("%0t: tracked_position expected %h got %h", $time, want.pos, got.pos);
          errors++;
        end
        if (m_axis_tdata[71:67] !== 5'd0) begin
          $display("%0t: padding expected %h got %h", $time, 5'd0, m_axis_tdata[71:67]);
          errors++;
        end
      end
    end
  end

endmodule
